FILE: design/dcs_pkg.sv
// Shared types and constants for the dosing cycle sequencer.
// No dependencies; every other design file refers to this package by scoped names.
package dcs_pkg;

    // Width of a tared scale reading
    localparam int WEIGHT_BITS = 16;

    // Signed width for weight comparisons. It covers the weight, the arm and settle
    // levels and the fill thresholds.
    localparam int CMP_BITS = ((WEIGHT_BITS > 16) ? WEIGHT_BITS : 16) + 2;

    // Configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // Register map
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_AUTO_ENABLE   = 3'd0,
        CFG_AUTO_DELAY    = 3'd1,
        CFG_TARGET        = 3'd2,
        CFG_CORRECTION    = 3'd3,
        CFG_REVERSE_TIME  = 3'd4,
        CFG_FAST_RATE     = 3'd5,
        CFG_SLOW_RATE     = 3'd6
    } t_cfg_addr;

    localparam logic [15:0] AUTO_DELAY_RESET = 16'd1000;

    // Command codes
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_ABORT = 2'd2
    } t_cmd;

    // Container removed / container settled levels
    localparam logic signed [CMP_BITS-1:0] ARM_LEVEL    = CMP_BITS'(-400);
    localparam logic signed [CMP_BITS-1:0] SETTLE_LEVEL = CMP_BITS'(-10);

    // Cycle duration is kept in ms up to the point where the 100 ms count saturates
    localparam int          DIFF_BITS      = 23;
    localparam logic [31:0] TIME_SAT_MS    = 32'd6553600;
    localparam logic [DIFF_BITS-1:0] TIME_SAT_CLAMP = 23'd6553500;

    // x/100 = ((x >> 2) * DIV25_MULT) >> DIV25_SHIFT, exact for x < 2^23
    localparam logic [21:0] DIV25_MULT  = 22'd2684355;
    localparam int          DIV25_SHIFT = 26;

    // (4*t)/5 = ((4*t) * DIV5_MULT) >> DIV5_SHIFT, exact for 4*t < 2^17
    localparam logic [17:0] DIV5_MULT  = 18'd209716;
    localparam int          DIV5_SHIFT = 20;

    // Configuration as seen by the core
    typedef struct packed {
        logic        auto_enable;
        logic [15:0] auto_delay;
        logic [14:0] target;
        logic [14:0] correction;
        logic [15:0] reverse_time;
        logic [15:0] fast_rate;
        logic [15:0] slow_rate;
        logic [14:0] slow_at;      // floor(target * 80 / 100)
    } t_cfg;

    // One loop request
    typedef struct packed {
        logic                          sample_valid;
        logic signed [WEIGHT_BITS-1:0] weight;
        logic [31:0]                   now_ms;
        logic [1:0]                    command;
    } t_item;

    // Core result, cycle time still in ms
    typedef struct packed {
        logic                          pump_enable;
        logic                          pump_reverse;
        logic [15:0]                   pump_rate;
        logic                          dosing;
        logic                          tare_request;
        logic                          cycle_finished;
        logic [DIFF_BITS-1:0]          rec_diff;
        logic signed [WEIGHT_BITS-1:0] last_weight;
    } t_mid;

    // Final result
    typedef struct packed {
        logic                          pump_enable;
        logic                          pump_reverse;
        logic [15:0]                   pump_rate;
        logic                          dosing;
        logic                          tare_request;
        logic                          cycle_finished;
        logic [15:0]                   cycle_time;
        logic signed [WEIGHT_BITS-1:0] last_weight;
    } t_result;

endpackage

FILE: design/dcs_core.sv
// Sequencer state and per-request control logic, closed by the core result register.
// Depends on dcs_pkg.
module dcs_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcs_pkg::t_cfg        i_cfg,
    input  logic                 i_in_valid,
    input  dcs_pkg::t_item       i_in,
    output logic                 o_in_ready,
    output logic                 o_mid_valid,
    output dcs_pkg::t_mid        o_mid,
    input  logic                 i_mid_ready
);

    // State registers
    logic signed [dcs_pkg::WEIGHT_BITS-1:0] r_held, n_held;
    logic                                   r_active, n_active;
    logic                                   r_started, n_started;
    logic                                   r_abort, n_abort;
    logic                                   r_armed, n_armed;
    logic                                   r_settle_timing, n_settle_timing;
    logic [31:0]                            r_settle_start, n_settle_start;
    logic [31:0]                            r_cycle_start, n_cycle_start;
    logic [31:0]                            r_rev_start, n_rev_start;
    logic                                   r_pump_on, n_pump_on;
    logic                                   r_dir, n_dir;
    logic [15:0]                            r_freq, n_freq;
    logic [dcs_pkg::DIFF_BITS-1:0]          r_rec_diff, n_rec_diff;
    logic signed [dcs_pkg::WEIGHT_BITS-1:0] r_rec_weight, n_rec_weight;

    logic          r_mid_valid;
    dcs_pkg::t_mid r_mid;

    logic                                n_tare;
    logic                                n_finished;
    logic signed [dcs_pkg::CMP_BITS-1:0] held_x;
    logic signed [dcs_pkg::CMP_BITS-1:0] stop_at;
    logic signed [dcs_pkg::CMP_BITS-1:0] slow_at_x;
    logic [31:0]                         settle_gap;
    logic [31:0]                         rev_gap;
    logic [31:0]                         cyc_gap;
    logic                                take;

    // Take a request when the result register is free or drains this cycle
    assign o_in_ready = !r_mid_valid || i_mid_ready;
    assign take       = i_in_valid && o_in_ready;

    // Fill thresholds
    assign stop_at   = dcs_pkg::CMP_BITS'(signed'({1'b0, i_cfg.target}))
                     - dcs_pkg::CMP_BITS'(signed'({1'b0, i_cfg.correction}));
    assign slow_at_x = signed'(dcs_pkg::CMP_BITS'({1'b0, i_cfg.slow_at}));

    // Step: sample, command, auto start, then cycle logic
    always_comb begin
        n_held          = r_held;
        n_active        = r_active;
        n_started       = r_started;
        n_abort         = r_abort;
        n_armed         = r_armed;
        n_settle_timing = r_settle_timing;
        n_settle_start  = r_settle_start;
        n_cycle_start   = r_cycle_start;
        n_rev_start     = r_rev_start;
        n_pump_on       = r_pump_on;
        n_dir           = r_dir;
        n_freq          = r_freq;
        n_rec_diff      = r_rec_diff;
        n_rec_weight    = r_rec_weight;
        n_tare          = 1'b0;
        n_finished      = 1'b0;
        settle_gap      = 32'd0;
        rev_gap         = 32'd0;
        cyc_gap         = 32'd0;

        // Capture a new sample
        if (i_in.sample_valid) begin
            n_held = i_in.weight;
        end
        held_x = dcs_pkg::CMP_BITS'(n_held);

        // Apply the command; the abort stays pending until a cycle runs
        if (i_in.command == dcs_pkg::CMD_START) begin
            n_active = 1'b1;
        end else if (i_in.command == dcs_pkg::CMD_ABORT) begin
            n_abort = 1'b1;
        end

        // Auto start: arm on removal, start once settled long enough
        if (i_cfg.auto_enable && !n_active) begin
            if (held_x < dcs_pkg::ARM_LEVEL) begin
                n_armed = 1'b1;
            end
            if (held_x > dcs_pkg::SETTLE_LEVEL && n_armed) begin
                if (!n_settle_timing) begin
                    n_settle_timing = 1'b1;
                    n_settle_start  = i_in.now_ms;
                end
                settle_gap = i_in.now_ms - n_settle_start;
                if (settle_gap > {16'd0, i_cfg.auto_delay}) begin
                    n_armed         = 1'b0;
                    n_active        = 1'b1;
                    n_settle_timing = 1'b0;
                end
            end
        end

        // Dosing cycle
        if (n_active) begin
            if (!n_started) begin
                n_started     = 1'b1;
                n_tare        = 1'b1;
                n_pump_on     = 1'b1;
                n_cycle_start = i_in.now_ms;
            end
            if (n_abort) begin
                n_dir     = 1'b0;
                n_abort   = 1'b0;
                n_active  = 1'b0;
                n_pump_on = 1'b0;
                n_started = 1'b0;
            end
            if (held_x >= stop_at) begin
                // Target reached: reverse, then finish after the suck-back time
                n_freq  = i_cfg.fast_rate;
                n_dir   = 1'b1;
                rev_gap = i_in.now_ms - n_rev_start;
                if (rev_gap > {16'd0, i_cfg.reverse_time}) begin
                    cyc_gap      = i_in.now_ms - n_cycle_start;
                    n_active     = 1'b0;
                    n_pump_on    = 1'b0;
                    n_started    = 1'b0;
                    n_rec_diff   = (cyc_gap >= dcs_pkg::TIME_SAT_MS) ?
                                   dcs_pkg::TIME_SAT_CLAMP : cyc_gap[dcs_pkg::DIFF_BITS-1:0];
                    n_rec_weight = n_held;
                    n_finished   = 1'b1;
                end
            end else begin
                // Still filling: slow down near target
                n_rev_start = i_in.now_ms;
                n_dir       = 1'b0;
                n_freq      = (held_x > slow_at_x) ? i_cfg.slow_rate : i_cfg.fast_rate;
            end
        end
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held          <= '0;
            r_active        <= 1'b0;
            r_started       <= 1'b0;
            r_abort         <= 1'b0;
            r_armed         <= 1'b0;
            r_settle_timing <= 1'b0;
            r_settle_start  <= '0;
            r_cycle_start   <= '0;
            r_rev_start     <= '0;
            r_pump_on       <= 1'b0;
            r_dir           <= 1'b0;
            r_freq          <= '0;
            r_rec_diff      <= '0;
            r_rec_weight    <= '0;
            r_mid_valid     <= 1'b0;
        end else begin
            if (take) begin
                r_held          <= n_held;
                r_active        <= n_active;
                r_started       <= n_started;
                r_abort         <= n_abort;
                r_armed         <= n_armed;
                r_settle_timing <= n_settle_timing;
                r_settle_start  <= n_settle_start;
                r_cycle_start   <= n_cycle_start;
                r_rev_start     <= n_rev_start;
                r_pump_on       <= n_pump_on;
                r_dir           <= n_dir;
                r_freq          <= n_freq;
                r_rec_diff      <= n_rec_diff;
                r_rec_weight    <= n_rec_weight;
            end
            if (o_in_ready) begin
                r_mid_valid <= i_in_valid;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mid.pump_enable    <= n_pump_on;
            r_mid.pump_reverse   <= n_dir;
            r_mid.pump_rate      <= n_freq;
            r_mid.dosing         <= n_started;
            r_mid.tare_request   <= n_tare;
            r_mid.cycle_finished <= n_finished;
            r_mid.rec_diff       <= n_rec_diff;
            r_mid.last_weight    <= n_rec_weight;
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

endmodule

FILE: design/dcs_out.sv
// Output stage: converts the recorded cycle duration to 100 ms units and holds the result.
// Depends on dcs_pkg.
module dcs_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mid_valid,
    input  dcs_pkg::t_mid       i_mid,
    output logic                o_mid_ready,
    output logic                o_valid,
    output dcs_pkg::t_result    o_result,
    input  logic                i_stall
);

    logic                  r_valid;
    dcs_pkg::t_result      r_result;
    logic [42:0]           prod;
    logic [15:0]           cycle_time;

    // Divide by 100 with a reciprocal multiply; the duration is below 2^23 ms
    assign prod       = 43'(i_mid.rec_diff[dcs_pkg::DIFF_BITS-1:2]) * 43'(dcs_pkg::DIV25_MULT);
    assign cycle_time = prod[dcs_pkg::DIV25_SHIFT +: 16];

    // Accept when empty or when the held result leaves
    assign o_mid_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_mid_ready) begin
            r_valid <= i_mid_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (o_mid_ready && i_mid_valid) begin
            r_result.pump_enable    <= i_mid.pump_enable;
            r_result.pump_reverse   <= i_mid.pump_reverse;
            r_result.pump_rate      <= i_mid.pump_rate;
            r_result.dosing         <= i_mid.dosing;
            r_result.tare_request   <= i_mid.tare_request;
            r_result.cycle_finished <= i_mid.cycle_finished;
            r_result.cycle_time     <= cycle_time;
            r_result.last_weight    <= i_mid.last_weight;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/dosing_cycle_sequencer.sv
// Top level of the dosing cycle sequencer: configuration registers, input register,
// core and output stage. Depends on dcs_pkg, dcs_core and dcs_out.
//
// One loop request (sample, timestamp, command) gives one result. A request is taken
// in every cycle as long as the output side keeps up; its result passes through the
// input register, the core result register and the output register. The core state is
// updated in the single cycle in which a request moves from the input register to the
// core result register, which is what allows the next request to follow directly. The
// 100 ms cycle-time division is a reciprocal multiply in the output stage. Configuration
// writes take effect on the next cycle; the user must make them while no request is in
// flight, which the block itself does not enforce.
module dosing_cycle_sequencer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration
    input  logic                                   i_cfg_wr_en,
    input  logic [dcs_pkg::CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  logic [dcs_pkg::CFG_DATA_BITS-1:0]      i_cfg_wdata,
    // Request channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_sample_valid,
    input  logic signed [dcs_pkg::WEIGHT_BITS-1:0] i_weight,
    input  logic [31:0]                            i_now_ms,
    input  logic [1:0]                             i_command,
    // Result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_pump_enable,
    output logic                                   o_pump_reverse,
    output logic [15:0]                            o_pump_rate,
    output logic                                   o_dosing,
    output logic                                   o_tare_request,
    output logic                                   o_cycle_finished,
    output logic [15:0]                            o_cycle_time,
    output logic signed [dcs_pkg::WEIGHT_BITS-1:0] o_last_weight
);

    dcs_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    dcs_pkg::t_item   r_in;
    logic             core_ready;
    logic             mid_valid;
    dcs_pkg::t_mid    mid;
    logic             mid_ready;
    dcs_pkg::t_result result;
    logic             in_ready;
    logic [16:0]      target_x4;
    logic [34:0]      slow_prod;

    // Slow threshold floor(target * 4 / 5) for a target write
    assign target_x4 = {i_cfg_wdata[14:0], 2'b00};
    assign slow_prod = 35'(target_x4) * 35'(dcs_pkg::DIV5_MULT);

    // Configuration registers; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_enable  <= 1'b0;
            r_cfg.auto_delay   <= dcs_pkg::AUTO_DELAY_RESET;
            r_cfg.target       <= '0;
            r_cfg.correction   <= '0;
            r_cfg.reverse_time <= '0;
            r_cfg.fast_rate    <= '0;
            r_cfg.slow_rate    <= '0;
            r_cfg.slow_at      <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                dcs_pkg::CFG_AUTO_ENABLE: begin
                    r_cfg.auto_enable <= i_cfg_wdata[0];
                end
                dcs_pkg::CFG_AUTO_DELAY: begin
                    r_cfg.auto_delay <= i_cfg_wdata;
                end
                dcs_pkg::CFG_TARGET: begin
                    r_cfg.target  <= i_cfg_wdata[14:0];
                    r_cfg.slow_at <= slow_prod[dcs_pkg::DIV5_SHIFT +: 15];
                end
                dcs_pkg::CFG_CORRECTION: begin
                    r_cfg.correction <= i_cfg_wdata[14:0];
                end
                dcs_pkg::CFG_REVERSE_TIME: begin
                    r_cfg.reverse_time <= i_cfg_wdata;
                end
                dcs_pkg::CFG_FAST_RATE: begin
                    r_cfg.fast_rate <= i_cfg_wdata;
                end
                dcs_pkg::CFG_SLOW_RATE: begin
                    r_cfg.slow_rate <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register
    assign in_ready = !r_in_valid || core_ready;
    assign o_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in.sample_valid <= i_sample_valid;
            r_in.weight       <= i_weight;
            r_in.now_ms       <= i_now_ms;
            r_in.command      <= i_command;
        end
    end

    dcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (r_in_valid),
        .i_in        (r_in),
        .o_in_ready  (core_ready),
        .o_mid_valid (mid_valid),
        .o_mid       (mid),
        .i_mid_ready (mid_ready)
    );

    dcs_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .o_mid_ready (mid_ready),
        .o_valid     (o_valid),
        .o_result    (result),
        .i_stall     (i_stall)
    );

    assign o_pump_enable    = result.pump_enable;
    assign o_pump_reverse   = result.pump_reverse;
    assign o_pump_rate      = result.pump_rate;
    assign o_dosing         = result.dosing;
    assign o_tare_request   = result.tare_request;
    assign o_cycle_finished = result.cycle_finished;
    assign o_cycle_time     = result.cycle_time;
    assign o_last_weight    = result.last_weight;

endmodule

FILE: design/dcs_checker.sv
// Port-level checks for the dosing cycle sequencer, bound to the top level.
// Depends on dcs_pkg and dosing_cycle_sequencer.
module dcs_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   o_valid,
    input  logic                                   i_stall,
    input  logic                                   o_pump_enable,
    input  logic                                   o_dosing,
    input  logic                                   o_cycle_finished,
    input  logic [15:0]                            o_cycle_time,
    input  logic signed [dcs_pkg::WEIGHT_BITS-1:0] o_last_weight
);

    // Hold a stalled result request
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_cycle_time) && $stable(o_last_weight))
        else $error("result payload changed while stalled");

    // Pump drive follows the active cycle
    a_pump_tracks_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pump_enable == o_dosing)
        else $error("pump enable differs from dosing");

    // A finished cycle leaves the pump stopped
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cycle_finished |-> !o_dosing && !o_pump_enable)
        else $error("cycle finished while still dosing");

endmodule

bind dosing_cycle_sequencer dcs_checker u_dcs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_pump_enable    (o_pump_enable),
    .o_dosing         (o_dosing),
    .o_cycle_finished (o_cycle_finished),
    .o_cycle_time     (o_cycle_time),
    .o_last_weight    (o_last_weight)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the dosing cycle sequencer (dosing_cycle_sequencer).
// Drives loop requests and register writes, predicts every pump result in a
// cycle-free model and compares. Depends on dcs_pkg and the design sources.
module tb_top;

    // Limits and pacing
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int LONG_HOLD    = 200;

    // Behavior constants
    localparam int ARM_BELOW     = -400;
    localparam int SETTLED_ABOVE = -10;
    localparam int SLOW_PCT      = 80;
    localparam int PCT_SCALE     = 100;
    localparam int MS_PER_TICK   = 100;

    // Codes outside the package maps
    localparam logic [1:0] CMD_RESERVED    = 2'd3;
    localparam logic [2:0] CFG_UNUSED_ADDR = 3'd7;

    // Idle modes for both sides
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SOME = 1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [dcs_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [dcs_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_sample_valid = 1'b0;
    logic signed [dcs_pkg::WEIGHT_BITS-1:0] i_weight = '0;
    logic [31:0] i_now_ms = '0;
    logic [1:0] i_command = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_pump_enable;
    logic o_pump_reverse;
    logic [15:0] o_pump_rate;
    logic o_dosing;
    logic o_tare_request;
    logic o_cycle_finished;
    logic [15:0] o_cycle_time;
    logic signed [dcs_pkg::WEIGHT_BITS-1:0] o_last_weight;

    dosing_cycle_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample_valid   (i_sample_valid),
        .i_weight         (i_weight),
        .i_now_ms         (i_now_ms),
        .i_command        (i_command),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pump_enable    (o_pump_enable),
        .o_pump_reverse   (o_pump_reverse),
        .o_pump_rate      (o_pump_rate),
        .o_dosing         (o_dosing),
        .o_tare_request   (o_tare_request),
        .o_cycle_finished (o_cycle_finished),
        .o_cycle_time     (o_cycle_time),
        .o_last_weight    (o_last_weight)
    );

    // Pending loop requests and expected pump outputs
    dcs_pkg::t_item   loop_req_q[$];
    dcs_pkg::t_result pump_out_q[$];

    int mismatches = 0;
    int cycle_count = 0;
    int reqs_made = 0;
    int tx_mode = IDLE_NONE;
    int rx_mode = IDLE_NONE;
    int hold_req = 0;

    // Register shadow
    bit          cfg_auto = 1'b0;
    logic [15:0] cfg_delay = dcs_pkg::AUTO_DELAY_RESET;
    logic [14:0] cfg_target = '0;
    logic [14:0] cfg_corr = '0;
    logic [15:0] cfg_suck = '0;
    logic [15:0] cfg_fast = '0;
    logic [15:0] cfg_slow = '0;

    // Sequencer state of the prediction
    logic signed [15:0] wt_held = '0;
    bit run_req = 1'b0;
    bit run_begun = 1'b0;
    bit abort_hold = 1'b0;
    bit armed = 1'b0;
    bit settling = 1'b0;
    logic [31:0] settle_t0 = '0;
    logic [31:0] run_t0 = '0;
    logic [31:0] reverse_t0 = '0;
    bit pump_on_m = 1'b0;
    bit pump_rev_m = 1'b0;
    logic [15:0] rate_m = '0;
    logic [15:0] time_rec_m = '0;
    logic signed [15:0] wt_rec_m = '0;

    // Request generator state
    logic [31:0] gen_ms = '0;
    int gen_wt = 0;

    // Advance the sequencer by one loop request and return its pump outputs
    function automatic dcs_pkg::t_result dose_step(input dcs_pkg::t_item it);
        dcs_pkg::t_result r;
        int wt;
        int stop_lvl;
        int slow_lvl;
        logic [31:0] span;
        bit tare_now;
        bit done_now;
        tare_now = 1'b0;
        done_now = 1'b0;
        if (it.sample_valid) wt_held = it.weight;
        if (it.command == dcs_pkg::CMD_START) run_req = 1'b1;
        else if (it.command == dcs_pkg::CMD_ABORT) abort_hold = 1'b1;
        wt = int'(wt_held);

        // Arm on container removal, start once settled for longer than the delay
        if (cfg_auto && !run_req) begin
            if (wt < ARM_BELOW) armed = 1'b1;
            if (wt > SETTLED_ABOVE && armed) begin
                if (!settling) begin
                    settling = 1'b1;
                    settle_t0 = it.now_ms;
                end
                span = it.now_ms - settle_t0;
                if (span > 32'(cfg_delay)) begin
                    armed = 1'b0;
                    run_req = 1'b1;
                    settling = 1'b0;
                end
            end
        end

        if (run_req) begin
            stop_lvl = int'(cfg_target) - int'(cfg_corr);
            if (!run_begun) begin
                run_begun = 1'b1;
                tare_now = 1'b1;
                pump_on_m = 1'b1;
                run_t0 = it.now_ms;
            end
            // Pending abort ends the cycle, the rest of the step still runs
            if (abort_hold) begin
                pump_rev_m = 1'b0;
                abort_hold = 1'b0;
                run_req = 1'b0;
                pump_on_m = 1'b0;
                run_begun = 1'b0;
            end
            if (wt >= stop_lvl) begin
                rate_m = cfg_fast;
                pump_rev_m = 1'b1;
                span = it.now_ms - reverse_t0;
                if (span > 32'(cfg_suck)) begin
                    span = it.now_ms - run_t0;
                    span = span / MS_PER_TICK;
                    run_req = 1'b0;
                    pump_on_m = 1'b0;
                    run_begun = 1'b0;
                    time_rec_m = (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
                    wt_rec_m = wt_held;
                    done_now = 1'b1;
                end
            end else begin
                slow_lvl = int'(cfg_target) * SLOW_PCT / PCT_SCALE;
                reverse_t0 = it.now_ms;
                pump_rev_m = 1'b0;
                rate_m = (wt > slow_lvl) ? cfg_slow : cfg_fast;
            end
        end

        r.pump_enable = pump_on_m;
        r.pump_reverse = pump_rev_m;
        r.pump_rate = rate_m;
        r.dosing = run_begun;
        r.tare_request = tare_now;
        r.cycle_finished = done_now;
        r.cycle_time = time_rec_m;
        r.last_weight = wt_rec_m;
        return r;
    endfunction

    // Wait cycles before the next request or result
    function automatic int unsigned pick_wait(input int mode);
        if (mode == IDLE_NONE) return 0;
        if (mode == IDLE_SOME) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        return $urandom_range(0, 17);
    endfunction

    // Mostly typical values, sometimes an extreme
    function automatic logic [15:0] pick_span(input int unsigned top, input int unsigned typ);
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'(top);
            default: return 16'($urandom_range(0, typ));
        endcase
    endfunction

    function automatic logic [1:0] pick_cmd();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return dcs_pkg::CMD_START;
        if (roll < 7) return dcs_pkg::CMD_ABORT;
        if (roll < 9) return CMD_RESERVED;
        return dcs_pkg::CMD_NONE;
    endfunction

    function automatic logic [31:0] pick_dt();
        if ($urandom_range(0, 49) == 0) return $urandom;
        return $urandom_range(0, 40);
    endfunction

    task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, tag, want, got);
            mismatches++;
        end
    endtask

    // Queue one loop request, time advanced by dt
    task automatic push_req(input bit sv, input int w, input logic [31:0] dt,
                            input logic [1:0] cmd);
        dcs_pkg::t_item req;
        gen_ms = gen_ms + dt;
        if (w > 32767) w = 32767;
        if (w < -32768) w = -32768;
        req.sample_valid = sv;
        req.weight = 16'(w);
        req.now_ms = gen_ms;
        req.command = cmd;
        loop_req_q.push_back(req);
        reqs_made++;
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        case (addr)
            dcs_pkg::CFG_AUTO_ENABLE:  cfg_auto = data[0];
            dcs_pkg::CFG_AUTO_DELAY:   cfg_delay = data;
            dcs_pkg::CFG_TARGET:       cfg_target = data[14:0];
            dcs_pkg::CFG_CORRECTION:   cfg_corr = data[14:0];
            dcs_pkg::CFG_REVERSE_TIME: cfg_suck = data;
            dcs_pkg::CFG_FAST_RATE:    cfg_fast = data;
            dcs_pkg::CFG_SLOW_RATE:    cfg_slow = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings(input logic [15:0] auto_en, input logic [15:0] delay,
                                 input logic [15:0] tgt, input logic [15:0] corr,
                                 input logic [15:0] suck, input logic [15:0] fast,
                                 input logic [15:0] slow);
        write_reg(dcs_pkg::CFG_AUTO_ENABLE, auto_en);
        write_reg(dcs_pkg::CFG_AUTO_DELAY, delay);
        write_reg(dcs_pkg::CFG_TARGET, tgt);
        write_reg(dcs_pkg::CFG_CORRECTION, corr);
        write_reg(dcs_pkg::CFG_REVERSE_TIME, suck);
        write_reg(dcs_pkg::CFG_FAST_RATE, fast);
        write_reg(dcs_pkg::CFG_SLOW_RATE, slow);
    endtask

    // Hold off until every request is taken and every result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (loop_req_q.size() != 0 || i_valid || pump_out_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Ramp the weight up to the stop level, then sit there through the suck-back
    task automatic add_fill_and_suck();
        int stop_lvl;
        int step;
        int n;
        logic [31:0] dt;
        logic [31:0] back_ms;
        stop_lvl = int'(cfg_target) - int'(cfg_corr);
        gen_wt = int'($urandom_range(0, 20)) - 10;
        n = 0;
        while (gen_wt < stop_lvl && n < 25) begin
            step = (stop_lvl - gen_wt) / int'($urandom_range(2, 8));
            if (step < 1 || $urandom_range(0, 4) == 0) step = stop_lvl - gen_wt;
            gen_wt += step;
            push_req($urandom_range(0, 3) != 0, gen_wt + int'($urandom_range(0, 6)) - 3,
                     pick_dt(), pick_cmd());
            n++;
        end
        back_ms = '0;
        n = 0;
        while (back_ms <= 32'(cfg_suck) && n < 10) begin
            dt = $urandom_range(0, int'(cfg_suck) / 3 + 4);
            back_ms += dt;
            push_req($urandom_range(0, 3) != 0, gen_wt + int'($urandom_range(0, 4)) - 2,
                     dt, pick_cmd());
            n++;
        end
        repeat ($urandom_range(1, 3)) push_req(1'b1, gen_wt, $urandom_range(1, 50),
                                              dcs_pkg::CMD_NONE);
    endtask

    // Remove the container, put it back, let it settle past the delay, then fill
    task automatic add_auto_dose();
        int w;
        int n;
        logic [31:0] dt;
        logic [31:0] settled_ms;
        repeat ($urandom_range(1, 3))
            push_req(1'b1, -int'($urandom_range(401, 32768)), $urandom_range(1, 50),
                     dcs_pkg::CMD_NONE);
        settled_ms = '0;
        n = 0;
        while (settled_ms <= 32'(cfg_delay) && n < 12) begin
            dt = $urandom_range(0, int'(cfg_delay) / 4 + 4);
            settled_ms += dt;
            if ($urandom_range(0, 9) == 0) w = -int'($urandom_range(10, 300));
            else w = int'($urandom_range(0, 40)) - 9;
            push_req($urandom_range(0, 4) != 0, w, dt, dcs_pkg::CMD_NONE);
            n++;
        end
        add_fill_and_suck();
    endtask

    task automatic add_manual_dose();
        if ($urandom_range(0, 5) == 0)
            push_req(1'b1, 0, $urandom_range(0, 20), dcs_pkg::CMD_ABORT);
        push_req(1'b1, int'($urandom_range(0, 8)) - 4, pick_dt(), dcs_pkg::CMD_START);
        add_fill_and_suck();
    endtask

    task automatic add_noise();
        repeat ($urandom_range(5, 20))
            push_req($urandom_range(0, 1), int'($urandom_range(0, 65535)) - 32768,
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100),
                     2'($urandom_range(0, 3)));
    endtask

    task automatic pick_settings();
        logic [15:0] tgt;
        tgt = pick_span(32767, 5000);
        load_settings(16'($urandom_range(0, 1)), pick_span(65535, 400), tgt,
                      pick_span(32767, int'(tgt) / 5 + 1), pick_span(65535, 150),
                      pick_span(65535, 65535), pick_span(65535, 65535));
        if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED_ADDR, 16'($urandom));
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stop a run that hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Request driver: hold each request until taken, then wait its drawn gap
    dcs_pkg::t_item cur_req;
    int unsigned tx_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) pump_out_q.push_back(dose_step(cur_req));
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (loop_req_q.size() > 0) begin
                    cur_req = loop_req_q.pop_front();
                    i_valid <= 1'b1;
                    i_sample_valid <= cur_req.sample_valid;
                    i_weight <= cur_req.weight;
                    i_now_ms <= cur_req.now_ms;
                    i_command <= cur_req.command;
                    tx_gap = pick_wait(tx_mode);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each taken result, draw the stall before the next
    dcs_pkg::t_result want;
    int unsigned rx_wait = 0;
    int hold_left = 0;
    int hold_ack = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pump_out_q.size() == 0) begin
                    $display("%0t: result with nothing expected", $time);
                    mismatches++;
                end else begin
                    want = pump_out_q.pop_front();
                    check_field("pump_enable", want.pump_enable, o_pump_enable);
                    check_field("pump_reverse", want.pump_reverse, o_pump_reverse);
                    check_field("pump_rate", want.pump_rate, o_pump_rate);
                    check_field("dosing", want.dosing, o_dosing);
                    check_field("tare_request", want.tare_request, o_tare_request);
                    check_field("cycle_finished", want.cycle_finished, o_cycle_finished);
                    check_field("cycle_time", want.cycle_time, o_cycle_time);
                    check_field("last_weight", want.last_weight, o_last_weight);
                end
                rx_wait = pick_wait(rx_mode);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            // Long hold-off so the block backs up and stalls the request side
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_ack != hold_req) begin
                hold_ack++;
                hold_left = LONG_HOLD;
            end
            i_stall <= (rx_wait > 0) || (hold_left > 0);
        end
    end

    // Stimulus
    int phase_no;
    int phase_end;
    int unsigned roll;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Removal arming, idle abort, settle timer, manual cycle, wrap and saturation
        load_settings(16'd1, 16'd5, 16'd1000, 16'd30, 16'd3, 16'hFFFF, 16'h1234);
        @(negedge i_clk);
        tx_mode = $urandom_range(0, 2);
        rx_mode = $urandom_range(0, 2);
        gen_ms = '0;
        push_req(1'b1, -32768, 0, dcs_pkg::CMD_NONE);
        push_req(1'b1, 0, 10, dcs_pkg::CMD_ABORT);
        push_req(1'b0, 32767, 2, dcs_pkg::CMD_NONE);
        push_req(1'b1, -200, 2, dcs_pkg::CMD_NONE);
        push_req(1'b1, -5, 6, dcs_pkg::CMD_NONE);
        push_req(1'b1, 0, 1, dcs_pkg::CMD_START);
        push_req(1'b1, 900, 4, dcs_pkg::CMD_START);
        push_req(1'b1, 970, 1, dcs_pkg::CMD_NONE);
        push_req(1'b0, 0, 4, dcs_pkg::CMD_NONE);
        push_req(1'b1, 32767, 32'hFFFF_FFC0, CMD_RESERVED);
        push_req(1'b1, 5000, 33, dcs_pkg::CMD_START);
        push_req(1'b1, 0, 6, dcs_pkg::CMD_START);
        push_req(1'b1, 500, 10, dcs_pkg::CMD_NONE);
        push_req(1'b1, 980, 7000000, dcs_pkg::CMD_ABORT);
        wait_idle();

        // Correction above target: negative stop level, zero suck-back
        load_settings(16'd0, 16'd0, 16'd10, 16'd32767, 16'd0, 16'd0, 16'hFFFF);
        write_reg(CFG_UNUSED_ADDR, 16'hFFFF);
        @(negedge i_clk);
        push_req(1'b1, -32768, 1, dcs_pkg::CMD_START);
        push_req(1'b1, -32757, 1, dcs_pkg::CMD_NONE);
        push_req(1'b1, 9, 1, dcs_pkg::CMD_START);
        wait_idle();

        // Full target, longest delay and suck-back, boundaries of both timers
        load_settings(16'd1, 16'hFFFF, 16'd32767, 16'd0, 16'hFFFF, 16'd1, 16'd2);
        @(negedge i_clk);
        push_req(1'b1, -401, 1, dcs_pkg::CMD_NONE);
        push_req(1'b1, -9, 1, dcs_pkg::CMD_NONE);
        push_req(1'b1, -9, 65535, dcs_pkg::CMD_NONE);
        push_req(1'b1, 32767, 1, dcs_pkg::CMD_NONE);
        push_req(1'b1, 26214, 1, dcs_pkg::CMD_NONE);
        push_req(1'b1, 26213, 1, dcs_pkg::CMD_NONE);
        push_req(1'b1, 32767, 65535, dcs_pkg::CMD_NONE);
        push_req(1'b1, 32767, 1, dcs_pkg::CMD_NONE);

        // Random phases of dosing sessions and noise under new settings each time
        phase_no = 0;
        phase_end = reqs_made + RANDOM_ITEMS;
        while (reqs_made < phase_end) begin
            wait_idle();
            pick_settings();
            @(negedge i_clk);
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            if (phase_no == 1 || $urandom_range(0, 5) == 0) hold_req++;
            repeat ($urandom_range(6, 14)) begin
                roll = $urandom_range(0, 99);
                if (roll < 40 && cfg_auto) add_auto_dose();
                else if (roll < 85) add_manual_dose();
                else add_noise();
            end
            phase_no++;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pump_out_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
design/dcs_pkg.sv
design/dcs_core.sv
design/dcs_out.sv
design/dosing_cycle_sequencer.sv
design/dcs_checker.sv
verif/tb_top.sv
